/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ispq_pkg.sv */
package ispq_pkg;

    localparam int ID_BITS           = 6;
    localparam int ID_SPACE          = 1 << ID_BITS;
    localparam int KIND_BITS         = 3;
    localparam int REQ_BITS          = 32;
    localparam int CNT_OUT_BITS      = 7;
    localparam int CFG_BITS          = 7;
    localparam int DEF_MAX_ENTRIES   = 64;
    localparam int DEF_PRIORITY_BITS = 32;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

    typedef enum logic [KIND_BITS-1:0] {
        K_INSERT = 3'd0,
        K_REMOVE = 3'd1,
        K_RAISE  = 3'd2,
        K_LOWER  = 3'd3,
        K_QUERY  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PLACE
    } t_state;

    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_HEAD,
        OSEL_CUR
    } t_osel;

    typedef struct packed {
        logic [KIND_BITS-1:0]       kind;
        logic [ID_BITS-1:0]         id;
        logic signed [REQ_BITS-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic                       ok;
        logic [ID_BITS-1:0]         out_id;
        logic signed [REQ_BITS-1:0] out_priority;
        logic [CNT_OUT_BITS-1:0]    count;
    } t_out_item;

    typedef struct packed {
        logic  load;
        logic  place;
        logic  unlink;
        logic  pop;
        logic  write_out;
        logic  ok;
        t_osel osel;
    } t_cmd;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 id_ok;
        logic                 present;
        logic                 cond;
        logic                 empty;
        logic                 full;
        logic                 out_free;
    } t_status;

endpackage

/* hw/rtl/ispq_ctrl.sv */
module ispq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ispq_pkg::t_status  i_status,
    output ispq_pkg::t_cmd     o_cmd
);

    ispq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ispq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.osel = ispq_pkg::OSEL_ZERO;
        case (r_state)
            ispq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ispq_pkg::S_EXEC;
                end
            end
            ispq_pkg::S_EXEC: begin
                case (i_status.kind)
                    ispq_pkg::K_INSERT: begin
                        o_cmd.ok = i_status.id_ok && !i_status.present && !i_status.full;
                        if (i_status.out_free) begin
                            o_cmd.place     = o_cmd.ok;
                            o_cmd.write_out = 1'b1;
                            n_state         = ispq_pkg::S_IDLE;
                        end
                    end
                    ispq_pkg::K_REMOVE: begin
                        o_cmd.ok = !i_status.empty;
                        if (i_status.out_free) begin
                            o_cmd.pop       = o_cmd.ok;
                            o_cmd.osel      = o_cmd.ok ? ispq_pkg::OSEL_HEAD
                                                       : ispq_pkg::OSEL_ZERO;
                            o_cmd.write_out = 1'b1;
                            n_state         = ispq_pkg::S_IDLE;
                        end
                    end
                    ispq_pkg::K_RAISE, ispq_pkg::K_LOWER: begin
                        // take the entry out first, put it back in order in S_PLACE once the output is free
                        if (i_status.present && i_status.cond) begin
                            o_cmd.unlink = 1'b1;
                            n_state      = ispq_pkg::S_PLACE;
                        end else if (i_status.out_free) begin
                            o_cmd.write_out = 1'b1;
                            n_state         = ispq_pkg::S_IDLE;
                        end
                    end
                    ispq_pkg::K_QUERY: begin
                        o_cmd.ok = i_status.present;
                        if (i_status.out_free) begin
                            o_cmd.osel      = o_cmd.ok ? ispq_pkg::OSEL_CUR
                                                       : ispq_pkg::OSEL_ZERO;
                            o_cmd.write_out = 1'b1;
                            n_state         = ispq_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.out_free) begin
                            o_cmd.write_out = 1'b1;
                            n_state         = ispq_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            ispq_pkg::S_PLACE: begin
                o_cmd.ok = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.place     = 1'b1;
                    o_cmd.write_out = 1'b1;
                    n_state         = ispq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ispq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/ispq_datapath.sv */
module ispq_datapath #(
    parameter int MAX_ENTRIES   = ispq_pkg::DEF_MAX_ENTRIES,
    parameter int PRIORITY_BITS = ispq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ispq_pkg::t_in_item              i_in,
    input  logic                            i_cfg_we,
    input  logic [ispq_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  ispq_pkg::t_cmd                  i_cmd,
    output ispq_pkg::t_status               o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ispq_pkg::t_out_item             o_out
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PB = PRIORITY_BITS;

    // request registers
    logic [ispq_pkg::KIND_BITS-1:0] r_kind;
    logic [ispq_pkg::ID_BITS-1:0]   r_id;
    logic signed [PB-1:0]           r_pr;
    logic signed [PB-1:0]           r_cur;
    logic                           r_present_rd;

    // per-id state
    logic signed [PB-1:0]           r_mem [ispq_pkg::ID_SPACE];
    logic [ispq_pkg::ID_SPACE-1:0]  r_present, n_present;
    logic [ispq_pkg::CFG_BITS-1:0]  r_limit;

    // sorted slots, head at index 0
    logic [ispq_pkg::ID_BITS-1:0]   r_sid [MAX_ENTRIES];
    logic signed [PB-1:0]           r_spr [MAX_ENTRIES];
    logic [ispq_pkg::ID_BITS-1:0]   n_sid [MAX_ENTRIES];
    logic signed [PB-1:0]           n_spr [MAX_ENTRIES];
    logic [CW-1:0]                  r_count, n_count;

    logic [MAX_ENTRIES-1:0]         w_gt, w_match, w_after;
    logic                           r_ovalid;
    ispq_pkg::t_out_item            r_out;
    logic                           w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ispq_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind       <= i_in.kind;
            r_id         <= i_in.id;
            r_pr         <= PB'(i_in.priority_req);
            r_cur        <= r_mem[i_in.id];
            r_present_rd <= r_present[i_in.id];
        end
        if (i_cmd.place) begin
            r_mem[r_id] <= r_pr;
        end
    end

    // slot compares, one per slot
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_gt[i]    = (CW'(i) < r_count) && (r_spr[i] > r_pr);
            w_match[i] = (CW'(i) < r_count) && (r_sid[i] == r_id);
        end
        // prefix or: slots at or behind the one leaving
        w_after = i_cmd.pop ? '1 : w_match;
        for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
            w_after = w_after | (w_after << s);
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_slot
        logic                         w_take_new;
        logic [ispq_pkg::ID_BITS-1:0] w_prev_id, w_next_id;
        logic signed [PB-1:0]         w_prev_pr, w_next_pr;

        if (g == 0) begin : g_first
            assign w_take_new = !w_gt[g];
            assign w_prev_id  = r_sid[g];
            assign w_prev_pr  = r_spr[g];
        end else begin : g_rest
            assign w_take_new = !w_gt[g] && w_gt[g-1];
            assign w_prev_id  = r_sid[g-1];
            assign w_prev_pr  = r_spr[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_next_id = r_sid[g];
            assign w_next_pr = r_spr[g];
        end else begin : g_inner
            assign w_next_id = r_sid[g+1];
            assign w_next_pr = r_spr[g+1];
        end

        always_comb begin
            n_sid[g] = r_sid[g];
            n_spr[g] = r_spr[g];
            if ((i_cmd.pop || i_cmd.unlink) && w_after[g]) begin
                n_sid[g] = w_next_id;
                n_spr[g] = w_next_pr;
            end else if (i_cmd.place && !w_gt[g]) begin
                n_sid[g] = w_take_new ? r_id : w_prev_id;
                n_spr[g] = w_take_new ? r_pr : w_prev_pr;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sid[g] <= n_sid[g];
            r_spr[g] <= n_spr[g];
        end
    end

    always_comb begin
        n_count   = r_count;
        n_present = r_present;
        if (i_cmd.place) begin
            n_count         = r_count + CW'(1);
            n_present[r_id] = 1'b1;
        end
        if (i_cmd.pop || i_cmd.unlink) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.pop) begin
            n_present[r_sid[0]] = 1'b0;
        end
    end

    assign w_out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_present <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_present <= n_present;
            if (i_cmd.write_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_out) begin
            r_out.ok     <= i_cmd.ok;
            r_out.out_id <= (i_cmd.osel == ispq_pkg::OSEL_HEAD) ? r_sid[0] : r_id;
            r_out.count  <= ispq_pkg::CNT_OUT_BITS'(n_count);
            case (i_cmd.osel)
                ispq_pkg::OSEL_HEAD: r_out.out_priority <= ispq_pkg::REQ_BITS'(r_spr[0]);
                ispq_pkg::OSEL_CUR:  r_out.out_priority <= ispq_pkg::REQ_BITS'(r_cur);
                default:             r_out.out_priority <= '0;
            endcase
        end
    end

    always_comb begin
        o_status.kind     = r_kind;
        o_status.id_ok    = (ispq_pkg::CFG_BITS'(r_id) < r_limit)
                         && (int'(r_id) < MAX_ENTRIES);
        o_status.present  = o_status.id_ok && r_present_rd;
        o_status.cond     = (r_kind == ispq_pkg::K_RAISE) ? (r_pr > r_cur) : (r_pr < r_cur);
        o_status.empty    = (r_count == '0);
        o_status.full     = (r_count >= CW'(MAX_ENTRIES));
        o_status.out_free = w_out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

/* hw/rtl/indexed_sorted_priority_queue.sv */
// the controller handles one request at a time and takes no new request
// until the result of the last one is written; insert, remove, query and
// refused requests are decided and written in S_EXEC, while a successful
// increase or decrease unlinks the slot in S_EXEC and re-places it in the
// sorted slot row in S_PLACE; the result waits there while the output stalls
// reset (synchronous, active low) empties the queue and sets id_limit to 64
module indexed_sorted_priority_queue #(
    parameter int MAX_ENTRIES   = ispq_pkg::DEF_MAX_ENTRIES,
    parameter int PRIORITY_BITS = ispq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ispq_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ispq_pkg::t_out_item           o_out,
    input  logic                          i_cfg_we,
    input  logic [ispq_pkg::CFG_BITS-1:0] i_cfg_data
);

    ispq_pkg::t_cmd    w_cmd;
    ispq_pkg::t_status w_status;

    ispq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ispq_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* hw/rtl/ispq_checker.sv */
`include "assert_macros.svh"

module ispq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ispq_pkg::t_out_item o_out
);

    // one request in flight: the input stalls right after a transfer
    `CHK_ASSERT(a_busy_after_in, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input taken while busy")

    // live count never exceeds the id space
    `CHK_ASSERT(a_count_range, i_clk, i_rst_n, o_out_valid |-> (o_out.count <= 7'd64), "count out of range")

    // no result is shown in the cycle after reset
    `CHK_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    // a stalled result stays
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)), "stalled result changed")

endmodule

bind indexed_sorted_priority_queue ispq_checker u_ispq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

/* bench/tb_indexed_sorted_priority_queue.sv */
`timescale 1ns / 1ps

module tb_indexed_sorted_priority_queue;

    localparam int NUM_IDS = ispq_pkg::DEF_MAX_ENTRIES;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    ispq_pkg::t_in_item i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    ispq_pkg::t_out_item o_out;
    logic i_cfg_we = 1'b0;
    logic [ispq_pkg::CFG_BITS-1:0] i_cfg_data = '0;

    indexed_sorted_priority_queue dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // queue model: ids kept head first, descending priority
    int unsigned q_ids[$];
    logic signed [31:0] q_prio[NUM_IDS];
    bit q_present[NUM_IDS];
    int unsigned q_limit = 64;

    ispq_pkg::t_in_item pending_items[$];
    ispq_pkg::t_out_item expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;

    task automatic report(input string what, input ispq_pkg::t_out_item got,
                          input ispq_pkg::t_out_item want);
        errors++;
        $display("mismatch %s: got ok=%0b id=%0d prio=%0d cnt=%0d want ok=%0b id=%0d prio=%0d cnt=%0d",
                 what, got.ok, got.out_id, got.out_priority, got.count,
                 want.ok, want.out_id, want.out_priority, want.count);
    endtask

    function automatic void queue_place(input int unsigned id, input logic signed [31:0] p);
        int pos;
        pos = 0;
        while (pos < q_ids.size() && q_prio[q_ids[pos]] > p) pos++;
        q_ids.insert(pos, id);
        q_prio[id] = p;
    endfunction

    function automatic void queue_unlink(input int unsigned id);
        for (int i = 0; i < q_ids.size(); i++)
            if (q_ids[i] == id) begin
                q_ids.delete(i);
                return;
            end
    endfunction

    function automatic ispq_pkg::t_out_item queue_apply(input ispq_pkg::t_in_item it);
        ispq_pkg::t_out_item r;
        bit id_ok, pres;
        int unsigned h;
        id_ok = it.id < q_limit;
        pres = id_ok && q_present[it.id];
        r = '0;
        r.out_id = it.id;
        case (it.kind)
            ispq_pkg::K_INSERT: if (id_ok && !pres && q_ids.size() < NUM_IDS) begin
                queue_place(it.id, it.priority_req);
                q_present[it.id] = 1'b1;
                r.ok = 1'b1;
            end
            ispq_pkg::K_REMOVE: if (q_ids.size() > 0) begin
                h = q_ids[0];
                r.out_id = 6'(h);
                r.out_priority = q_prio[h];
                void'(q_ids.pop_front());
                q_present[h] = 1'b0;
                r.ok = 1'b1;
            end
            ispq_pkg::K_RAISE, ispq_pkg::K_LOWER: if (pres) begin
                if ((it.kind == ispq_pkg::K_RAISE && it.priority_req > q_prio[it.id]) ||
                    (it.kind == ispq_pkg::K_LOWER && it.priority_req < q_prio[it.id])) begin
                    queue_unlink(it.id);
                    queue_place(it.id, it.priority_req);
                    r.ok = 1'b1;
                end
            end
            ispq_pkg::K_QUERY: if (pres) begin
                r.out_priority = q_prio[it.id];
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = 7'(q_ids.size());
        return r;
    endfunction

    function automatic ispq_pkg::t_in_item make_item(input logic [2:0] kind,
                                                     input int unsigned id,
                                                     input logic [31:0] p);
        ispq_pkg::t_in_item it;
        it.kind = kind;
        it.id = 6'(id);
        it.priority_req = p;
        return it;
    endfunction

    function automatic logic [31:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 7) - 3;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom_range(0, 15) << 16;
        endcase
    endfunction

    function automatic ispq_pkg::t_in_item rand_item(input int unsigned id_span);
        logic [2:0] k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) k = ispq_pkg::K_INSERT;
        else if (r < 55) k = ispq_pkg::K_REMOVE;
        else if (r < 70) k = ispq_pkg::K_RAISE;
        else if (r < 85) k = ispq_pkg::K_LOWER;
        else if (r < 96) k = ispq_pkg::K_QUERY;
        else k = 3'($urandom_range(5, 7));
        return make_item(k, $urandom_range(0, id_span - 1), rand_prio());
    endfunction

    // driver: bursts and gaps, holds payload while stalled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 1) ? $urandom_range(0, 6) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
            stall_mode <= (cycles % 300 < 60) ? 0 : ((cycles % 300 < 200) ? 1 : 2);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor: predicts on input transfer, checks on output transfer
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(queue_apply(i_in));
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected", o_out, '0);
                end else begin
                    ispq_pkg::t_out_item w;
                    w = expected_results.pop_front();
                    if (o_out.ok !== w.ok) report("ok", o_out, w);
                    else if (o_out.out_id !== w.out_id) report("out_id", o_out, w);
                    else if (o_out.out_priority !== w.out_priority) report("out_priority", o_out, w);
                    else if (o_out.count !== w.count) report("count", o_out, w);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (i_in_valid || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [ispq_pkg::CFG_BITS-1:0] v);
        @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        q_limit = (v > NUM_IDS) ? NUM_IDS : v;
    endtask

    initial begin
        int unsigned lim;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ties, refusals
        pending_items.push_back(make_item(ispq_pkg::K_REMOVE, 63, 32'h0));
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 0, 32'h7fffffff));
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 63, 32'h80000000));
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 5, 32'h00010000));
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 6, 32'h00010000));
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 6, 32'h00020000));
        pending_items.push_back(make_item(ispq_pkg::K_QUERY, 63, 32'h0));
        pending_items.push_back(make_item(ispq_pkg::K_QUERY, 7, 32'h0));
        pending_items.push_back(make_item(ispq_pkg::K_RAISE, 5, 32'h00010000));
        pending_items.push_back(make_item(ispq_pkg::K_RAISE, 5, 32'h00010001));
        pending_items.push_back(make_item(ispq_pkg::K_LOWER, 0, 32'h7fffffff));
        pending_items.push_back(make_item(ispq_pkg::K_LOWER, 0, 32'h00010001));
        pending_items.push_back(make_item(ispq_pkg::K_RAISE, 9, 32'h1));
        pending_items.push_back(make_item(ispq_pkg::K_LOWER, 9, 32'h1));
        pending_items.push_back(make_item(3'd5, 5, 32'hffffffff));
        pending_items.push_back(make_item(3'd7, 0, 32'h0));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(ispq_pkg::K_REMOVE, 0, 32'h0));
        drain();

        // limit of one and zero, then out of range
        set_limit(7'd1);
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 1, 32'h5));
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 0, 32'h5));
        pending_items.push_back(make_item(ispq_pkg::K_REMOVE, 0, 32'h0));
        drain();
        set_limit(7'd0);
        pending_items.push_back(make_item(ispq_pkg::K_INSERT, 0, 32'h5));
        pending_items.push_back(make_item(ispq_pkg::K_QUERY, 0, 32'h5));
        drain();
        set_limit(7'd127);

        // random phases with varied limits and id ranges
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: lim = 64;
                1: lim = 4;
                2: lim = 16;
                3: lim = 1;
                4: lim = 100;
                5: lim = 33;
                default: lim = $urandom_range(2, 64);
            endcase
            set_limit(7'(lim));
            for (int n = 0; n < 85; n++)
                pending_items.push_back(rand_item(ph == 0 ? 64 : ((lim > 64 || lim < 2) ? 64 : lim + 1)));
            drain();
        end
        set_limit(7'd64);
        for (int n = 0; n < 70; n++)
            pending_items.push_back(make_item(ispq_pkg::K_INSERT, n % 64, rand_prio()));
        for (int n = 0; n < 70; n++)
            pending_items.push_back(make_item(ispq_pkg::K_REMOVE, $urandom_range(0, 63), 32'h0));
        drain();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

/* indexed_sorted_priority_queue.f */
+incdir+hw/rtl
hw/rtl/ispq_pkg.sv
hw/rtl/ispq_ctrl.sv
hw/rtl/ispq_datapath.sv
hw/rtl/indexed_sorted_priority_queue.sv
hw/rtl/ispq_checker.sv
bench/tb_indexed_sorted_priority_queue.sv
